### sv/mdp_pkg.sv
// Shared constants for the disjoint palindrome counter.
package mdp_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int CHAR_W      = 8;
    localparam int MINLEN_W    = 9;
    localparam int COUNT_W     = 9;
    localparam int COUNT_MAX   = 511;
    localparam logic [MINLEN_W-1:0] MINLEN_RST = MINLEN_W'(1);

endpackage

### sv/max_disjoint_palindromes_min_len_unit.sv
// Top level: string loader, min_len register, solver and result strobe.
//
// Bytes arrive one item per clock while busy is low; each is written to the
// text RAM (bytes past MAX_LEN are dropped and set the overflow flag). The item
// with is_last raises busy and starts the closing pass over n stored bytes:
// for each start position, right to left, one row of palindrome flags is
// built one end position per cycle from the previous row (two one-bit RAM
// banks), the shortest qualifying palindrome is picked on the fly, and the
// count DP RAM is read and written back. If min_len exceeds n, the pass is
// skipped and the count is zero. Result count and overflow appear for
// exactly one cycle with done, and busy drops in that same cycle.
// The receiver cannot stall, so done must be sampled when it is seen.
// Write min_len only while busy is low; 0 acts as 1.
module max_disjoint_palindromes_min_len_unit
    import mdp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CHAR_W-1:0]   char_in,
    input  logic                is_last,
    input  logic                cfg_we,
    input  logic [MINLEN_W-1:0] cfg_wdata,
    output logic                done,
    output logic [COUNT_W-1:0]  count,
    output logic                overflow
);

    localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int CW  = LW;
    localparam int CWX = (CW > COUNT_W) ? CW : COUNT_W;

    logic [MINLEN_W-1:0] min_len_reg;
    logic [LW-1:0]       len_reg;
    logic                ovf_reg;
    logic                ovf_hold_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                overflow_reg;

    logic                accept;
    logic                room;
    logic [LW-1:0]       len_next;
    logic                go;
    logic [MINLEN_W-1:0] k_eff;
    logic [AW-1:0]       text_raddr;
    logic [CHAR_W-1:0]   text_rdata;
    logic                sol_done;
    logic [CW-1:0]       sol_result;
    logic [COUNT_W-1:0]  count_next;

    always_comb
    begin
        accept   = start && !busy_reg;
        room     = (len_reg < LW'(MAX_LEN));
        len_next = room ? (len_reg + LW'(1)) : len_reg;
        go       = accept && is_last;
        k_eff    = (min_len_reg == '0) ? MINLEN_W'(1) : min_len_reg;
        // Clamp the count to the port width.
        if (CWX'(sol_result) > CWX'(COUNT_MAX))
        begin
            count_next = COUNT_W'(COUNT_MAX);
        end
        else
        begin
            count_next = COUNT_W'(sol_result);
        end
    end

    // Text store: written by the loader, read by the row scan.
    mdp_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_text
    (
        .clk   (clk),
        .we    (accept && room),
        .waddr (len_reg[AW-1:0]),
        .wdata (char_in),
        .raddr (text_raddr),
        .rdata (text_rdata)
    );

    mdp_solver #(.MAX_LEN(MAX_LEN)) u_solver
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .n          (len_next),
        .k          (k_eff),
        .text_raddr (text_raddr),
        .text_rdata (text_rdata),
        .done       (sol_done),
        .result     (sol_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg  <= MINLEN_RST;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            ovf_hold_reg <= 1'b0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                min_len_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (is_last)
                begin
                    // Hand the string to the solver and rearm for the next one.
                    ovf_hold_reg <= ovf_reg || !room;
                    len_reg      <= '0;
                    ovf_reg      <= 1'b0;
                    busy_reg     <= 1'b1;
                end
                else
                begin
                    len_reg <= len_next;
                    ovf_reg <= ovf_reg || !room;
                end
            end
            if (sol_done)
            begin
                busy_reg     <= 1'b0;
                done_reg     <= 1'b1;
                count_reg    <= count_next;
                overflow_reg <= ovf_hold_reg;
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign count    = count_reg;
    assign overflow = overflow_reg;

endmodule

### sv/mdp_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module mdp_ram
    import mdp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = MAX_LEN_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### sv/mdp_solver.sv
// Closing pass: palindrome rows built right to left, fused with the count DP.
module mdp_solver
    import mdp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int LW  = $clog2(MAX_LEN + 1),
    localparam int CW  = LW,
    localparam int OW  = ((LW > MINLEN_W) ? LW : MINLEN_W) + 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [LW-1:0]       n,
    input  logic [MINLEN_W-1:0] k,
    output logic [AW-1:0]       text_raddr,
    input  logic [CHAR_W-1:0]   text_rdata,
    output logic                done,
    output logic [CW-1:0]       result
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROW   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_BRD   = 5'b01000,
        S_BWR   = 5'b10000
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         i_reg;
    logic [AW-1:0]         j_reg;
    logic [AW-1:0]         jd_reg;
    logic                  v_reg;
    logic [CHAR_W-1:0]     si_reg;
    logic                  hit_reg;
    logic [AW-1:0]         jh_reg;
    logic [OW-1:0]         lo_reg;
    logic [LW-1:0]         n_reg;
    logic [MINLEN_W-1:0]   k_reg;
    logic                  bank_reg;
    logic [CW-1:0]         pbest_reg;
    logic                  done_reg;
    logic [CW-1:0]         res_reg;

    logic [CHAR_W-1:0]     sv;
    logic [AW-1:0]         dif;
    logic                  rd_a;
    logic                  rd_b;
    logic                  prev_rd;
    logic                  pbit;
    logic                  hit_now;
    logic [LW-1:0]         jh1;
    logic [CW-1:0]         best_rd;
    logic [CW-1:0]         bval;
    logic [CW-1:0]         take;
    logic [CW-1:0]         best_i;
    logic [AW-1:0]         prev_addr;

    always_comb
    begin
        sv        = (jd_reg == i_reg) ? text_rdata : si_reg;
        dif       = jd_reg - i_reg;
        prev_rd   = bank_reg ? rd_a : rd_b;
        pbit      = (text_rdata == sv) && ((dif < AW'(2)) || prev_rd);
        hit_now   = v_reg && pbit && !hit_reg && (OW'(jd_reg) >= lo_reg);
        prev_addr = j_reg - AW'(1);
        jh1       = LW'(jh_reg) + LW'(1);
        bval      = (jh1 == n_reg) ? '0 : best_rd;
        take      = bval + CW'(1);
        if (hit_reg && (take > pbest_reg))
        begin
            best_i = take;
        end
        else
        begin
            best_i = pbest_reg;
        end
    end

    assign text_raddr = j_reg;

    // Ping-pong row banks: current row written, previous row read.
    mdp_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_row_a
    (
        .clk   (clk),
        .we    (v_reg && !bank_reg),
        .waddr (jd_reg),
        .wdata (pbit),
        .raddr (prev_addr),
        .rdata (rd_a)
    );

    mdp_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_row_b
    (
        .clk   (clk),
        .we    (v_reg && bank_reg),
        .waddr (jd_reg),
        .wdata (pbit),
        .raddr (prev_addr),
        .rdata (rd_b)
    );

    mdp_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_best
    (
        .clk   (clk),
        .we    (state_reg == S_BWR),
        .waddr (i_reg),
        .wdata (best_i),
        .raddr (jh1[AW-1:0]),
        .rdata (best_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            v_reg     <= 1'b0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            v_reg    <= 1'b0;
            if (v_reg)
            begin
                if (jd_reg == i_reg)
                begin
                    si_reg <= text_rdata;
                end
                if (hit_now)
                begin
                    hit_reg <= 1'b1;
                    jh_reg  <= jd_reg;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        n_reg     <= n;
                        k_reg     <= k;
                        pbest_reg <= '0;
                        if (OW'(k) > OW'(n))
                        begin
                            done_reg <= 1'b1;
                            res_reg  <= '0;
                        end
                        else
                        begin
                            i_reg     <= AW'(n - LW'(1));
                            j_reg     <= AW'(n - LW'(1));
                            hit_reg   <= 1'b0;
                            lo_reg    <= OW'(n) + OW'(k) - OW'(2);
                            bank_reg  <= 1'b0;
                            state_reg <= S_ROW;
                        end
                    end
                end
                S_ROW:
                begin
                    v_reg  <= 1'b1;
                    jd_reg <= j_reg;
                    if (LW'(j_reg) == n_reg - LW'(1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        j_reg <= j_reg + AW'(1);
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_BRD;
                end
                S_BRD:
                begin
                    state_reg <= S_BWR;
                end
                S_BWR:
                begin
                    pbest_reg <= best_i;
                    if (i_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        res_reg   <= best_i;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_reg - AW'(1);
                        j_reg     <= i_reg - AW'(1);
                        hit_reg   <= 1'b0;
                        lo_reg    <= OW'(i_reg) + OW'(k_reg) - OW'(2);
                        bank_reg  <= !bank_reg;
                        state_reg <= S_ROW;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_pipe_from_row: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg |-> $past(state_reg == S_ROW))
        else $error("row pipeline stage valid without an issue");

    a_hit_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (jh_reg >= i_reg))
        else $error("palindrome end before its start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result issued while still solving");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BWR) |-> $past(state_reg == S_BRD))
        else $error("count written without its read");

endmodule

### tb/sv/tb.sv
// Testbench for the disjoint palindrome counter: directed table, then random strings.
`timescale 1ns / 100ps

module tb;
    import mdp_pkg::*;

    localparam int  STR_MAX     = MAX_LEN_DEF;
    localparam int  ITEM_GOAL   = 1850;
    localparam int  CALM_ITEMS  = 200;     // final stretch with no idling
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [COUNT_W-1:0] cnt;
        logic               ovf;
    } outcome_t;

    // One directed row: either a min_len write or one item of a string.
    typedef struct {
        bit                  is_cfg;
        logic [MINLEN_W-1:0] mlen;
        logic [CHAR_W-1:0]   ch;
        bit                  last;
        bit                  typed;   // expected result given in the row
        logic [COUNT_W-1:0]  tcnt;
        bit                  tovf;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CHAR_W-1:0]   char_in;
    logic                is_last;
    logic                cfg_we;
    logic [MINLEN_W-1:0] cfg_wdata;
    logic                done;
    logic [COUNT_W-1:0]  count;
    logic                overflow;

    max_disjoint_palindromes_min_len_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .char_in   (char_in),
        .is_last   (is_last),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .count     (count),
        .overflow  (overflow)
    );

    // Predictor state: its own copy of min_len and the string so far.
    logic [MINLEN_W-1:0] pred_min_len;
    logic [CHAR_W-1:0]   text_q[$];
    bit                  text_ovf;
    outcome_t            pending_q[$];   // results still owed by the block

    bit     failed;
    bit     allow_idle;
    int     items_sent;
    longint cycles;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Is text_q[lo..hi] a palindrome?
    function automatic bit span_is_pal(int lo, int hi);
        while (lo < hi)
        begin
            if (text_q[lo] != text_q[hi])
                return 1'b0;
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    // Greatest number of disjoint palindromes of length >= min_len in text_q.
    function automatic logic [COUNT_W-1:0] max_disjoint_pals();
        int n;
        int k;
        int take;
        int best_from[STR_MAX+1];
        n = text_q.size();
        k = (pred_min_len == '0) ? 1 : int'(pred_min_len);
        if (k > n)
            return '0;
        foreach (best_from[i])
            best_from[i] = 0;
        for (int i = n - 1; i >= 0; i--)
        begin
            best_from[i] = best_from[i+1];
            // take only the shortest qualifying palindrome starting at i
            for (int j = i + k - 1; j < n; j++)
            begin
                if (span_is_pal(i, j))
                begin
                    take = 1 + best_from[j+1];
                    if (take > best_from[i])
                        best_from[i] = take;
                    break;
                end
            end
        end
        return (best_from[0] > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(best_from[0]);
    endfunction

    // Offer one item, hold it until accepted, then advance the predictor.
    task automatic send_item(logic [CHAR_W-1:0] c, bit l, bit typed = 0,
                             logic [COUNT_W-1:0] tcnt = '0, bit tovf = 0);
        outcome_t res;
        int       gap;
        start   <= 1'b1;
        char_in <= c;
        is_last <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        items_sent++;
        if (text_q.size() < STR_MAX)
            text_q.push_back(c);
        else
            text_ovf = 1'b1;
        if (l)
        begin
            res.cnt = max_disjoint_pals();
            res.ovf = text_ovf;
            if (typed)
            begin
                res.cnt = tcnt;
                res.ovf = tovf;
            end
            pending_q.push_back(res);
            text_q.delete();
            text_ovf = 1'b0;
        end
        // drop start for a random burst now and then
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write min_len once the block is idle and every result is in.
    task automatic write_min_len(logic [MINLEN_W-1:0] v);
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pred_min_len = v;
    endtask

    // Random string: mostly short and palindrome-rich, sometimes full-range bytes.
    task automatic send_random_string(int len);
        logic [CHAR_W-1:0] s[$];
        int                mode;
        int                half;
        mode = $urandom_range(0, 9);
        if (mode < 4)
        begin
            // mirrored halves: whole string is a palindrome, inner ones too
            half = (len + 1) / 2;
            for (int i = 0; i < half; i++)
                s.push_back(CHAR_W'($urandom_range(0, 2)));
            for (int i = len - half - 1; i >= 0; i--)
                s.push_back(s[i]);
        end
        else
        begin
            for (int i = 0; i < len; i++)
                s.push_back((mode < 8) ? CHAR_W'($urandom_range(0, 2)) : CHAR_W'($urandom));
        end
        foreach (s[i])
            send_item(s[i], i == len - 1);
    endtask

    // Check each strobed result against the oldest one owed.
    always @(posedge clk)
    begin
        outcome_t exp_res;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result count=%0d overflow=%0b", $time, count, overflow);
                failed = 1'b1;
            end
            else
            begin
                exp_res = pending_q.pop_front();
                if (count !== exp_res.cnt)
                begin
                    $display("%0t: count mismatch expected %0d actual %0d",
                             $time, exp_res.cnt, count);
                    failed = 1'b1;
                end
                if (overflow !== exp_res.ovf)
                begin
                    $display("%0t: overflow mismatch expected %0b actual %0b",
                             $time, exp_res.ovf, overflow);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        row_t dir_rows[$];
        int   len;
        int   strings;

        failed       = 1'b0;
        allow_idle   = 1'b1;
        items_sent   = 0;
        cycles       = 0;
        pred_min_len = MINLEN_RST;
        text_ovf     = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        char_in      = '0;
        is_last      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;

        // Directed rows; typed results are the obvious ones.
        dir_rows = '{
            '{0, 0,   8'h61, 1, 1, 1, 0},   // single byte after reset: one palindrome
            '{0, 0,   8'hFF, 0, 0, 0, 0},
            '{0, 0,   8'h00, 0, 0, 0, 0},
            '{0, 0,   8'hFF, 1, 1, 3, 0},   // each byte on its own
            '{1, 0,   8'h00, 0, 0, 0, 0},   // zero minimum acts as one
            '{0, 0,   8'h07, 1, 1, 1, 0},
            '{1, 2,   8'h00, 0, 0, 0, 0},
            '{0, 0,   8'h01, 0, 0, 0, 0},
            '{0, 0,   8'h02, 0, 0, 0, 0},
            '{0, 0,   8'h01, 1, 0, 0, 0},
            '{0, 0,   8'h01, 0, 0, 0, 0},
            '{0, 0,   8'h01, 0, 0, 0, 0},
            '{0, 0,   8'h02, 0, 0, 0, 0},
            '{0, 0,   8'h02, 1, 0, 0, 0},
            '{1, 3,   8'h00, 0, 0, 0, 0},   // minimum longer than the string
            '{0, 0,   8'h05, 0, 0, 0, 0},
            '{0, 0,   8'h05, 1, 1, 0, 0},
            '{1, 511, 8'h00, 0, 0, 0, 0},
            '{0, 0,   8'h09, 1, 1, 0, 0},
            '{1, 2,   8'h00, 0, 0, 0, 0},
            '{0, 0,   8'hAA, 0, 0, 0, 0},
            '{0, 0,   8'h55, 0, 0, 0, 0},
            '{0, 0,   8'h55, 0, 0, 0, 0},
            '{0, 0,   8'hAA, 1, 0, 0, 0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].is_cfg)
                write_min_len(dir_rows[r].mlen);
            else
                send_item(dir_rows[r].ch, dir_rows[r].last, dir_rows[r].typed,
                          dir_rows[r].tcnt, dir_rows[r].tovf);
        end

        // Full-length string of one byte with the largest useful minimum.
        write_min_len(MINLEN_W'(256));
        for (int i = 0; i < STR_MAX; i++)
            send_item(8'h41, i == STR_MAX - 1, i == STR_MAX - 1, 1, 0);
        // One byte too many, the final one dropped.
        for (int i = 0; i <= STR_MAX; i++)
            send_item(8'h41, i == STR_MAX, i == STR_MAX, 1, 1);
        // Overflowing random string with minimum one.
        write_min_len(MINLEN_W'(1));
        len = STR_MAX + $urandom_range(2, 5);
        for (int i = 0; i < len; i++)
            send_item(CHAR_W'($urandom_range(0, 3)), i == len - 1);

        // Random phases: change min_len every few dozen strings.
        strings = 0;
        while (items_sent < ITEM_GOAL)
        begin
            if (strings % 40 == 0)
                write_min_len(($urandom_range(0, 7) == 0) ? MINLEN_W'($urandom)
                                                          : MINLEN_W'($urandom_range(0, 6)));
            if (items_sent > ITEM_GOAL - CALM_ITEMS)
                allow_idle = 1'b0;
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            send_random_string(len);
            strings++;
        end
        start <= 1'b0;

        // Hold until every result is in, then let stray strobes show.
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
